[rtl/cds_pkg.sv]
`default_nettype none

package cds_pkg;

  localparam int unsigned StackDepthDef = 16;

  typedef enum logic [1:0] {
    MODE_ACTIVE = 2'd0,
    MODE_FALSE  = 2'd1,
    MODE_NEVER  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ACT_IF     = 3'd0,
    ACT_IFDEF  = 3'd1,
    ACT_IFNDEF = 3'd2,
    ACT_ELSE   = 3'd3,
    ACT_ELIF   = 3'd4,
    ACT_ENDIF  = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_ELSE_AGAIN = 3'd1,
    ERR_ELSE_OUT   = 3'd2,
    ERR_ELIF_OUT   = 3'd3,
    ERR_ENDIF_OUT  = 3'd4,
    ERR_OVERFLOW   = 3'd5,
    ERR_BAD_NAME   = 3'd6
  } err_e;

  typedef struct packed {
    logic [2:0] action;
    logic       cond_true;
    logic       name_defined;
    logic       name_valid;
  } cds_req_t;

  typedef struct packed {
    logic       emit_lines;
    logic [1:0] cur_mode;
    logic [4:0] nest_depth;
    logic       cond_used;
    logic [2:0] err_code;
  } cds_rsp_t;

  typedef struct packed {
    mode_e mode;
    logic  else_seen;
  } cds_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cds_shift_t;

endpackage

`default_nettype wire

[rtl/cds_cell.sv]
`default_nettype none

module cds_cell import cds_pkg::*; (
  input  wire        clk_i,
  input  cds_shift_t shift_i,
  input  cds_entry_t up_i,
  input  cds_entry_t dn_i,
  output cds_entry_t q_o
);

  cds_entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i.push) begin
      entry_q <= up_i;
    end else if (shift_i.pop) begin
      entry_q <= dn_i;
    end
  end

  assign q_o = entry_q;

endmodule

`default_nettype wire

[rtl/cds_ctrl.sv]
`default_nettype none

module cds_ctrl import cds_pkg::*; #(
  parameter  int unsigned STACK_DEPTH = StackDepthDef,
  localparam int unsigned LW          = $clog2(STACK_DEPTH + 1)
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        accept_i,
  input  cds_req_t   req_i,
  input  cds_entry_t below_i,
  output cds_entry_t top_o,
  output cds_shift_t shift_o,
  output cds_rsp_t   rsp_o
);

  mode_e           mode_q, mode_d, new_mode;
  logic            else_q, else_d;
  logic [LW-1:0]   level_q, level_d;
  logic            push, pop, used, full, empty, want;
  err_e            err;
  act_e            act;
  logic [LW+4:0]   depth_ext;

  assign act   = act_e'(req_i.action);
  assign full  = (level_q == LW'(STACK_DEPTH));
  assign empty = (level_q == '0);
  assign want  = (act == ACT_IFDEF) ? req_i.name_defined : !req_i.name_defined;

  always_comb begin
    mode_d   = mode_q;
    else_d   = else_q;
    level_d  = level_q;
    push     = 1'b0;
    pop      = 1'b0;
    used     = 1'b0;
    err      = ERR_NONE;
    new_mode = MODE_NEVER;
    unique case (act)
      ACT_IF: begin
        if (full) begin
          err = ERR_OVERFLOW;
        end else begin
          push = 1'b1;
          if (mode_q == MODE_ACTIVE) begin
            used     = 1'b1;
            new_mode = req_i.cond_true ? MODE_ACTIVE : MODE_FALSE;
          end
        end
      end
      ACT_IFDEF, ACT_IFNDEF: begin
        if (mode_q == MODE_ACTIVE) begin
          used = 1'b1;
          if (req_i.name_valid) begin
            new_mode = want ? MODE_ACTIVE : MODE_FALSE;
          end else begin
            new_mode = MODE_FALSE;
            err      = ERR_BAD_NAME;
          end
        end
        if (full) begin
          err = ERR_OVERFLOW;
        end else begin
          push = 1'b1;
        end
      end
      ACT_ELSE, ACT_ELIF: begin
        if (empty) begin
          err = (act == ACT_ELIF) ? ERR_ELIF_OUT : ERR_ELSE_OUT;
        end else if (else_q) begin
          err = ERR_ELSE_AGAIN;
        end else begin
          unique case (mode_q)
            MODE_ACTIVE: mode_d = MODE_NEVER;
            MODE_FALSE: begin
              if (act == ACT_ELIF) begin
                used   = 1'b1;
                mode_d = req_i.cond_true ? MODE_ACTIVE : MODE_FALSE;
              end else begin
                mode_d = MODE_ACTIVE;
              end
            end
            default: mode_d = mode_q;
          endcase
          else_d = (act == ACT_ELSE);
        end
      end
      ACT_ENDIF: begin
        if (empty) begin
          err = ERR_ENDIF_OUT;
        end else begin
          pop     = 1'b1;
          mode_d  = below_i.mode;
          else_d  = below_i.else_seen;
          level_d = level_q - LW'(1);
        end
      end
      default: ;
    endcase
    if (push) begin
      mode_d  = new_mode;
      else_d  = 1'b0;
      level_d = level_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ACTIVE;
      else_q  <= 1'b0;
      level_q <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      else_q  <= else_d;
      level_q <= level_d;
    end
  end

  assign top_o.mode      = mode_q;
  assign top_o.else_seen = else_q;
  assign shift_o.push    = accept_i & push;
  assign shift_o.pop     = accept_i & pop;

  assign depth_ext        = {5'd0, level_d};
  assign rsp_o.emit_lines = (mode_d == MODE_ACTIVE);
  assign rsp_o.cur_mode   = mode_d;
  assign rsp_o.nest_depth = depth_ext[4:0];
  assign rsp_o.cond_used  = used;
  assign rsp_o.err_code   = err;

endmodule

`default_nettype wire

[rtl/cds_obuf.sv]
`default_nettype none

module cds_obuf import cds_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      push_i,
  input  cds_rsp_t rsp_i,
  output logic     stall_o,
  output logic     valid_o,
  input  wire      stall_i,
  output cds_rsp_t rsp_o
);

  logic     out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  cds_rsp_t out_q, out_d, skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || !stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        if (push_i) begin
          out_d = rsp_i;
        end
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = rsp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign stall_o = skid_valid_q;
  assign valid_o = out_valid_q;
  assign rsp_o   = out_q;

endmodule

`default_nettype wire

[rtl/conditional_directive_stack_top.sv]
// An accepted result is registered in output (or skid) register and shown at out_valid_o.
// Throughput: one request per cycle unless in_stall_o; push/pop shift the stack one cell.
// in_stall_o is registered and rises only when both the output and skid registers hold data.
// Reset (rst_ni low, async): mode active, depth zero, output and skid registers empty.
// Stack cells beneath the top carry no reset; each is written by a push before it is read.
`default_nettype none

module conditional_directive_stack_top import cds_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_stall_o,
  input  cds_req_t in_req_i,
  output logic     out_valid_o,
  input  wire      out_stall_i,
  output cds_rsp_t out_rsp_o
);

  logic       accept;
  cds_entry_t top;
  cds_shift_t shift;
  cds_rsp_t   rsp;
  cds_entry_t cell_q [STACK_DEPTH];

  assign accept = in_valid_i & ~in_stall_o;

  cds_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .below_i  (cell_q[0]),
    .top_o    (top),
    .shift_o  (shift),
    .rsp_o    (rsp)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cds_entry_t up, dn;
    if (i == 0) begin : g_first
      assign up = top;
    end else begin : g_mid
      assign up = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign dn = cell_q[i];
    end else begin : g_inner
      assign dn = cell_q[i+1];
    end
    cds_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .up_i    (up),
      .dn_i    (dn),
      .q_o     (cell_q[i])
    );
  end

  cds_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .rsp_i   (rsp),
    .stall_o (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

[rtl/cds_chk.sv]
`default_nettype none

module cds_chk import cds_pkg::*; (
  input wire      clk_i,
  input wire      rst_ni,
  input wire      in_stall_o,
  input wire      out_valid_o,
  input wire      out_stall_i,
  input cds_rsp_t out_rsp_o
);

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_emit_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.emit_lines == (out_rsp_o.cur_mode == MODE_ACTIVE)))
    else $error("emit_lines disagrees with cur_mode");

  a_codes_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.cur_mode != 2'd3 && out_rsp_o.err_code != 3'd7))
    else $error("illegal mode or error code");

  a_no_use_on_branch_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.err_code == ERR_ELSE_AGAIN || out_rsp_o.err_code == ERR_ELSE_OUT
      || out_rsp_o.err_code == ERR_ELIF_OUT || out_rsp_o.err_code == ERR_ENDIF_OUT)
    |-> !out_rsp_o.cond_used)
    else $error("condition consumed by a rejected branch directive");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

endmodule

bind conditional_directive_stack_top cds_chk u_cds_chk (.*);

`default_nettype wire
